FILE: rtl/svpwm_pkg.sv
// Shared types, constants and tables for the SVPWM duty unit.
`timescale 1ns / 1ps
`default_nettype none
package svpwm_pkg;
    localparam int V_W          = 16;  // d/q voltage width
    localparam int CS_W         = 17;  // Q15 sin/cos with headroom
    localparam int BUS_W        = 16;  // bus voltage register width
    localparam int ZW           = 34;  // CORDIC datapath width
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [ZW-1:0] INV_GAIN_Q30 = 34'sh026DD3B6A;
    localparam logic [16:0] SQRT3_Q15 = 17'd56756;
    localparam logic REG_BUS_VOLTAGE = 1'b0;

    typedef struct packed {
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
        logic signed [V_W-1:0]  q;
        logic signed [V_W-1:0]  d;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic signed [ZW-1:0] atan_turn(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            4'd0:  v = 34'sh020000000;
            4'd1:  v = 34'sh012E4051E;
            4'd2:  v = 34'sh009FB385B;
            4'd3:  v = 34'sh0051111D4;
            4'd4:  v = 34'sh0028B0D43;
            4'd5:  v = 34'sh00145D7E1;
            4'd6:  v = 34'sh000A2F61E;
            4'd7:  v = 34'sh000517C55;
            4'd8:  v = 34'sh00028BE53;
            4'd9:  v = 34'sh000145F2F;
            4'd10: v = 34'sh0000A2F98;
            4'd11: v = 34'sh0000517CC;
            4'd12: v = 34'sh000028BE6;
            4'd13: v = 34'sh0000145F3;
            4'd14: v = 34'sh00000A2FA;
            default: v = 34'sh00000517D;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/svpwm_front.sv
// Front end: accepts requests and runs the pipelined CORDIC sin/cos.
`timescale 1ns / 1ps
`default_nettype none
module svpwm_front #(
    parameter int ANGLE_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  signed [svpwm_pkg::V_W-1:0] i_q,
    input  wire  signed [svpwm_pkg::V_W-1:0] i_d,
    input  wire         [ANGLE_BITS-1:0]     i_angle,
    input  svpwm_pkg::t_q_status             i_qstat,
    output logic                             o_push,
    output svpwm_pkg::t_item                 o_item
);
    import svpwm_pkg::*;
    localparam int N = CORDIC_STEPS;

    logic [N:0]              r_v;
    logic signed [ZW-1:0]    r_x [0:N];
    logic signed [ZW-1:0]    r_y [0:N];
    logic signed [ZW-1:0]    r_z [0:N];
    logic signed [V_W-1:0]   r_q [0:N];
    logic signed [V_W-1:0]   r_d [0:N];
    logic [1:0]              r_quad [0:N];
    logic signed [ZW-1:0]    n_x [0:N-1];
    logic signed [ZW-1:0]    n_y [0:N-1];
    logic signed [ZW-1:0]    n_z [0:N-1];
    logic                    en;
    logic [31:0]             ph;
    logic signed [ZW-1:0]    xs, ys;
    logic signed [CS_W-1:0]  cc, ss;

    assign en      = !(r_v[N] && i_qstat.full);
    assign o_stall = !en;
    assign o_push  = r_v[N] && !i_qstat.full;
    assign ph      = {i_angle, {(32-ANGLE_BITS){1'b0}}};

    for (genvar i = 0; i < N; i++) begin : g_step
        always_comb begin
            if (!r_z[i][ZW-1]) begin
                n_x[i] = r_x[i] - (r_y[i] >>> i);
                n_y[i] = r_y[i] + (r_x[i] >>> i);
                n_z[i] = r_z[i] - atan_turn(4'(i));
            end else begin
                n_x[i] = r_x[i] + (r_y[i] >>> i);
                n_y[i] = r_y[i] - (r_x[i] >>> i);
                n_z[i] = r_z[i] + atan_turn(4'(i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]    <= INV_GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= {4'b0, ph[29:0]};
            r_q[0]    <= i_q;
            r_d[0]    <= i_d;
            r_quad[0] <= ph[31:30];
            for (int i = 0; i < N; i++) begin
                r_x[i+1]    <= n_x[i];
                r_y[i+1]    <= n_y[i];
                r_z[i+1]    <= n_z[i];
                r_q[i+1]    <= r_q[i];
                r_d[i+1]    <= r_d[i];
                r_quad[i+1] <= r_quad[i];
            end
        end
    end

    // Q30 -> Q15 floor, then fold the quadrant back in.
    always_comb begin
        xs = r_x[N] >>> 15;
        ys = r_y[N] >>> 15;
        cc = xs[CS_W-1:0];
        ss = ys[CS_W-1:0];
        o_item.q = r_q[N];
        o_item.d = r_d[N];
        unique case (r_quad[N])
            2'd0: begin o_item.c = cc;  o_item.s = ss;  end
            2'd1: begin o_item.c = -ss; o_item.s = cc;  end
            2'd2: begin o_item.c = -cc; o_item.s = -ss; end
            default: begin o_item.c = ss; o_item.s = -cc; end
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/svpwm_queue.sv
// Short request queue between the CORDIC front end and the duty back end.
`timescale 1ns / 1ps
`default_nettype none
module svpwm_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  svpwm_pkg::t_item      i_item,
    input  wire                   i_pop,
    output svpwm_pkg::t_item      o_item,
    output svpwm_pkg::t_q_status  o_stat
);
    import svpwm_pkg::*;
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_item         r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

FILE: rtl/svpwm_back.sv
// Back end: inverse Park/Clarke, common-mode shift and per-phase duty divide.
`timescale 1ns / 1ps
`default_nettype none
module svpwm_back #(
    parameter int DUTY_BITS = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  svpwm_pkg::t_item             i_item,
    input  svpwm_pkg::t_q_status         i_qstat,
    output logic                         o_pop,
    input  wire  [svpwm_pkg::BUS_W-1:0]  i_bus,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [DUTY_BITS-1:0]         o_duty_a,
    output logic [DUTY_BITS-1:0]         o_duty_b,
    output logic [DUTY_BITS-1:0]         o_duty_c
);
    import svpwm_pkg::*;
    localparam int PW  = V_W + CS_W;        // product width
    localparam int AW  = PW + 1;            // alpha/beta
    localparam int WW  = 53;                // twice phase voltage
    localparam int NW  = 56;                // phase time numerator
    localparam int RW  = BUS_W + DUTY_BITS; // divider remainder
    localparam int XW  = NW + DUTY_BITS;
    localparam int D   = DUTY_BITS;
    localparam int ST  = 7;                 // stages before the divider
    localparam logic [D-1:0] FULL = {D{1'b1}};

    logic            en;
    logic [ST+D:0]   r_v;   // bit ST+D is the output register
    logic signed [PW-1:0] r_pdc, r_pqs, r_pds, r_pqc;
    logic signed [AW-1:0] r_al, r_be;
    logic signed [WW-1:0] r_w0a, r_ab, r_sb;
    logic signed [WW-1:0] r_w [0:2];
    logic signed [WW-1:0] r_w5 [0:2];
    logic signed [WW:0]   r_mm;
    logic signed [NW-1:0] r_n [0:2];
    logic [RW-1:0]   r_rem [0:D][0:2];
    logic [D-1:0]    r_qt  [0:D][0:2];
    logic            r_neg [0:D][0:2];
    logic            r_sat [0:D][0:2];
    logic [D-1:0]    r_duty [0:2];
    logic signed [WW-1:0] mx, mn;
    logic signed [NW-1:0] base;

    assign en      = !(r_v[ST+D] && i_stall);
    assign o_pop   = en && !i_qstat.empty;
    assign o_valid = r_v[ST+D];
    assign o_duty_a = r_duty[0];
    assign o_duty_b = r_duty[1];
    assign o_duty_c = r_duty[2];
    assign base    = NW'({i_bus, 31'b0});

    always_comb begin
        mx = r_w[0];
        mn = r_w[0];
        for (int k = 1; k < 3; k++) begin
            if (r_w[k] > mx) mx = r_w[k];
            if (r_w[k] < mn) mn = r_w[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[ST+D-1:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [NW-1:0] n;
        logic [XW-1:0] x;
        logic [RW-1:0] dv;
        if (en) begin
            // products
            r_pdc <= i_item.d * i_item.c;
            r_pqs <= i_item.q * i_item.s;
            r_pds <= i_item.d * i_item.s;
            r_pqc <= i_item.q * i_item.c;
            // alpha, beta
            r_al <= AW'(r_pdc) - AW'(r_pqs);
            r_be <= AW'(r_pds) + AW'(r_pqc);
            // scaled terms
            r_w0a <= WW'(r_al) <<< 16;
            r_ab  <= WW'(r_al) <<< 15;
            r_sb  <= WW'($signed({1'b0, SQRT3_Q15}) * r_be);
            // phase voltages
            r_w[0] <= r_w0a;
            r_w[1] <= r_sb - r_ab;
            r_w[2] <= -r_ab - r_sb;
            // common mode
            for (int k = 0; k < 3; k++) r_w5[k] <= r_w[k];
            r_mm <= (WW+1)'(mx) + (WW+1)'(mn);
            // numerators
            for (int k = 0; k < 3; k++)
                r_n[k] <= base + (NW'(r_w5[k]) <<< 1) - NW'(r_mm);
            // clamp flags and scaled dividend (den low 32 bits are zero)
            for (int k = 0; k < 3; k++) begin
                n = r_n[k];
                x = {n, {D{1'b0}}} - XW'(n);
                r_neg[0][k] <= (n <= 0);
                r_sat[0][k] <= ({8'b0, n[NW-1:32]} >= 32'(i_bus));
                r_rem[0][k] <= x[BUS_W+32+D-1:32];
                r_qt[0][k]  <= '0;
            end
            // restoring divide, one quotient bit per stage
            for (int i = 0; i < D; i++) begin
                dv = RW'(i_bus) << (D-1-i);
                for (int k = 0; k < 3; k++) begin
                    r_neg[i+1][k] <= r_neg[i][k];
                    r_sat[i+1][k] <= r_sat[i][k];
                    if (r_rem[i][k] >= dv) begin
                        r_rem[i+1][k] <= r_rem[i][k] - dv;
                        r_qt[i+1][k]  <= r_qt[i][k] | (D'(1) << (D-1-i));
                    end else begin
                        r_rem[i+1][k] <= r_rem[i][k];
                        r_qt[i+1][k]  <= r_qt[i][k];
                    end
                end
            end
            for (int k = 0; k < 3; k++)
                r_duty[k] <= r_neg[D][k] ? '0 : (r_sat[D][k] ? FULL : r_qt[D][k]);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/svpwm_duty_from_dq_voltage_unit.sv
// Top level of the SVPWM duty unit: d/q voltage and angle in, three phase duties out.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------
//  in      | request   | i_in_valid / o_in_stall    | q, d voltage (mV), angle
//  out     | result    | o_out_valid / i_out_stall  | duty_a, duty_b, duty_c
//  cfg     | APB write | psel penable pwrite pready | bus_voltage_mv at 0x0
//
// One request per cycle sustained while the output is not stalled. A request passes
// through 17 front stages (input register, 16 CORDIC steps), the queue register, then
// 8 + DUTY_BITS back stages (7 datapath, one divide step per duty bit, output register).
// Reset is synchronous and clears handshake/control state; bus voltage returns to
// 12000 mV, and a bus voltage of zero is used as 1 mV. A stalled output freezes the back
// end; the front keeps taking requests until the 4-deep queue fills, then raises o_in_stall.
`timescale 1ns / 1ps
`default_nettype none
module svpwm_duty_from_dq_voltage_unit #(
    parameter int ANGLE_BITS = 16,
    parameter int DUTY_BITS  = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  signed [svpwm_pkg::V_W-1:0] i_q_voltage_mv,
    input  wire  signed [svpwm_pkg::V_W-1:0] i_d_voltage_mv,
    input  wire         [ANGLE_BITS-1:0]     i_electrical_angle,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [DUTY_BITS-1:0]             o_duty_a,
    output logic [DUTY_BITS-1:0]             o_duty_b,
    output logic [DUTY_BITS-1:0]             o_duty_c,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [2:0]                       paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import svpwm_pkg::*;

    logic [BUS_W-1:0] r_bus;
    logic [BUS_W-1:0] bus_eff;
    logic             push, pop;
    t_item            f_item, q_item;
    t_q_status        qstat;

    // config register
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_BUS_VOLTAGE) ? {16'b0, r_bus} : '0;
    assign bus_eff = (r_bus == '0) ? BUS_W'(1) : r_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= BUS_W'(12000);
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_BUS_VOLTAGE) begin
            r_bus <= pwdata[BUS_W-1:0];
        end
    end

    svpwm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_q     (i_q_voltage_mv),
        .i_d     (i_d_voltage_mv),
        .i_angle (i_electrical_angle),
        .i_qstat (qstat),
        .o_push  (push),
        .o_item  (f_item)
    );

    svpwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (qstat)
    );

    svpwm_back #(.DUTY_BITS(DUTY_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (q_item),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .i_bus    (bus_eff),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_duty_a (o_duty_a),
        .o_duty_b (o_duty_b),
        .o_duty_c (o_duty_c)
    );
endmodule
`default_nettype wire

FILE: rtl/svpwm_checker.sv
// Port-level checker for the SVPWM duty unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module svpwm_checker #(
    parameter int ANGLE_BITS = 16,
    parameter int DUTY_BITS  = 8
) (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input wire [DUTY_BITS-1:0] o_duty_a,
    input wire [DUTY_BITS-1:0] o_duty_b,
    input wire [DUTY_BITS-1:0] o_duty_c,
    input wire                 pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_duty_a) && $stable(o_duty_b) && $stable(o_duty_c))
        else $error("stalled duties changed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result out of reset");
endmodule

bind svpwm_duty_from_dq_voltage_unit svpwm_checker #(
    .ANGLE_BITS(ANGLE_BITS),
    .DUTY_BITS (DUTY_BITS)
) u_svpwm_checker (.*);
`default_nettype wire

FILE: sim/tb_svpwm_duty_from_dq_voltage_unit.sv
// Testbench for the SVPWM duty unit: random and directed d/q commands checked against a model.
`timescale 1ns / 1ps
`default_nettype none
module tb_svpwm_duty_from_dq_voltage_unit;
    import svpwm_pkg::*;

    localparam int ANGLE_BITS = 16;
    localparam int DUTY_BITS  = 8;
    localparam int N_RANDOM   = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;  // extra settle cycles after the last result

    typedef struct packed {
        logic signed [15:0] q;
        logic signed [15:0] d;
        logic [15:0]        angle;
    } t_cmd;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_duty;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    logic signed [15:0] i_q_voltage_mv = '0;
    logic signed [15:0] i_d_voltage_mv = '0;
    logic [15:0] i_electrical_angle = '0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire o_in_stall, o_out_valid, pready;
    wire [7:0] o_duty_a, o_duty_b, o_duty_c;
    wire [31:0] prdata;

    always #5 i_clk = ~i_clk;

    svpwm_duty_from_dq_voltage_unit #(.ANGLE_BITS(ANGLE_BITS), .DUTY_BITS(DUTY_BITS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_q_voltage_mv(i_q_voltage_mv), .i_d_voltage_mv(i_d_voltage_mv),
        .i_electrical_angle(i_electrical_angle),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_duty_a(o_duty_a), .o_duty_b(o_duty_b), .o_duty_c(o_duty_c),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // model copy of the bus voltage register
    logic [15:0] bus_mv_model = 16'd12000;

    t_cmd  cmd_pending[$];
    t_duty duty_expected[$];
    int    n_errors = 0;
    int    n_checked = 0;
    int    cycle_count = 0;
    logic  hold_off = 1'b0;  // long receiver stall for the pressure phase

    // atan table, one entry per CORDIC step, 2^32 per turn
    function automatic longint atan_step(int i);
        longint tab[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
        return tab[i];
    endfunction

    function automatic longint duty_of(longint num, longint den);
        if (num <= 0) return 0;
        if (num >= den) return 255;
        return (num * 255) / den;
    endfunction

    // Inverse Park + Clarke with min/max common-mode shift, duties clamped and truncated.
    function automatic t_duty svpwm_duty(t_cmd cmd, logic [15:0] bus_reg);
        longint x, y, z, t, dx, dy, cc, ss, cs, sn, q, d, alpha, beta, mx, mn, base, den;
        longint w[3];
        longint r[3];
        logic [31:0] ph;
        t_duty res;
        ph = {cmd.angle, 16'h0};
        x = 64'h26DD3B6A;
        y = 0;
        z = ph[29:0];
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                t = x - dx; y = y + dy; z -= atan_step(i);
            end else begin
                t = x + dx; y = y - dy; z += atan_step(i);
            end
            x = t;
        end
        cc = x >>> 15;
        ss = y >>> 15;
        case (ph[31:30])
            2'd0: begin cs = cc;  sn = ss;  end
            2'd1: begin cs = -ss; sn = cc;  end
            2'd2: begin cs = -cc; sn = -ss; end
            default: begin cs = ss; sn = -cc; end
        endcase
        q = cmd.q;
        d = cmd.d;
        alpha = d * cs - q * sn;
        beta  = d * sn + q * cs;
        w[0] = alpha * 65536;
        w[1] = -alpha * 32768 + 56756 * beta;
        w[2] = -alpha * 32768 - 56756 * beta;
        mx = w[0]; mn = w[0];
        for (int k = 1; k < 3; k++) begin
            if (w[k] > mx) mx = w[k];
            if (w[k] < mn) mn = w[k];
        end
        base = longint'(bus_reg == 0 ? 16'd1 : bus_reg);
        den = base <<< 32;
        base = base * 64'sd2147483648;
        for (int k = 0; k < 3; k++) r[k] = duty_of(base + 2 * w[k] - mx - mn, den);
        res.a = r[0][7:0];
        res.b = r[1][7:0];
        res.c = r[2][7:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        n_errors++;
    endtask

    // Driver: request valid held until accepted, random gap between requests.
    int gap_in = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            duty_expected.push_back(svpwm_duty(cmd_pending.pop_front(), bus_mv_model));
            gap_in = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) gap_in = 0;
            if (gap_in == 0 && cmd_pending.size() > 0) begin
                i_q_voltage_mv     <= cmd_pending[0].q;
                i_d_voltage_mv     <= cmd_pending[0].d;
                i_electrical_angle <= cmd_pending[0].angle;
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (gap_in > 0) begin
                gap_in--;
            end else if (cmd_pending.size() > 0) begin
                i_in_valid         <= 1'b1;
                i_q_voltage_mv     <= cmd_pending[0].q;
                i_d_voltage_mv     <= cmd_pending[0].d;
                i_electrical_angle <= cmd_pending[0].angle;
            end
        end
    end

    // Monitor: checks each accepted result, draws a random stall per result.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_duty want;
        cycle_count++;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (duty_expected.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = duty_expected.pop_front();
                    n_checked++;
                    if (o_duty_a !== want.a) report_mismatch("duty_a", o_duty_a, want.a);
                    if (o_duty_b !== want.b) report_mismatch("duty_b", o_duty_b, want.b);
                    if (o_duty_c !== want.c) report_mismatch("duty_c", o_duty_c, want.c);
                end
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
            end
            if (hold_off) begin
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic apb_write(logic [15:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(REG_BUS_VOLTAGE) << 2; pwdata <= {16'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        bus_mv_model = value;
    endtask

    task automatic add_cmd(int q, int d, int angle);
        t_cmd c;
        c.q = 16'(q); c.d = 16'(d); c.angle = 16'(angle);
        cmd_pending.push_back(c);
    endtask

    // wait until every request is sent and every result seen, then let the pipe settle
    task automatic drain();
        while (cmd_pending.size() > 0 || i_in_valid || duty_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        int m;
        for (int i = 0; i < n; i++) begin
            m = $urandom_range(0, 9);
            // mix of full-range values, small vectors, d = 0 and angle edges
            add_cmd(m < 2 ? $urandom_range(0, 31) - 16 : $urandom_range(0, 65535),
                    m == 2 ? 0 : (m < 2 ? $urandom_range(0, 31) - 16 : $urandom_range(0, 65535)),
                    m == 3 ? 16'hFFFF * $urandom_range(0, 1) : $urandom_range(0, 65535));
        end
    endtask

    initial begin
        int bus_set[6];
        bus_set = '{65535, 1, 0, 24000, 5000, 300};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset bus value, zero vector, extremes, d = 0 with both q signs,
        // sector boundaries and overmodulation.
        add_cmd(0, 0, 0);
        add_cmd(32767, 0, 0);
        add_cmd(-32768, 0, 16384);
        add_cmd(-5000, 0, 100);
        add_cmd(5000, 0, 65535);
        add_cmd(0, 32767, 0);
        add_cmd(0, -32768, 32768);
        add_cmd(32767, 32767, 49152);
        add_cmd(-32768, -32768, 10923);
        add_cmd(3000, 4000, 21845);
        add_cmd(-3000, 4000, 43691);
        add_cmd(1000, -1000, 54613);
        add_cmd(1, 1, 1);
        add_cmd(-1, -1, 65535);
        drain();

        // bus extremes, zero treated as 1 mV
        foreach (bus_set[j]) begin
            apb_write(16'(bus_set[j]));
            add_cmd(2000, 0, 0);
            add_cmd(0, -1, 30000);
            add_random(N_RANDOM / 8);
            drain();
        end

        // Pressure: receiver holds off while requests keep coming until input stalls.
        apb_write(16'd12000);
        add_random(N_RANDOM / 4);
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
        drain();

        $display("Checked %0d duty results over %0d bus settings, incl. zero bus,",
                 n_checked, 8);
        $display("d = 0 path, overmodulation and a long output stall.");
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
